// ===== hw/rtl/act_pkg.sv =====
// ----------------------------------------------------------------------------
// Access control table package
// Table size, index widths, item kinds, status codes and sequencer states.
// ----------------------------------------------------------------------------
package act_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int UID_W   = 32;
    localparam int RIGHT_W = 8;
    localparam int ENTRY_W = UID_W + RIGHT_W;

    localparam logic [1:0] KIND_CHECK  = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [UID_W-1:0]   user;
        logic [RIGHT_W-1:0] rights;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/access_control_table_top.sv =====
// ----------------------------------------------------------------------------
// Access control table
// Maps user ids to rights masks; check, set and delete against a slot table.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one word per request: kind, user id,
// rights bits and kernel flag. Output channel (o_valid/i_ready) returns one
// word per request: rights found, granted and status.
// The default rights register is written through i_cfg_wr_en/i_cfg_wr_data
// and takes effect at once; write it only while the block is idle.
// Each request scans every slot of the table through one user id comparator,
// one slot per cycle from a RAM with registered read. An accepted word goes
// through S_SCAN, then S_WRITE for the update, then S_OUT, where o_valid is
// high. One request is in flight at a time: a new word is not accepted until
// the result of the last one is taken. A stalled receiver holds the result
// in the output register and the block stays not ready until it is taken.
// Reset clears all slot valid bits and the default rights to zero; the slot
// contents need no clearing.
// ----------------------------------------------------------------------------
module access_control_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [act_pkg::RIGHT_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic [act_pkg::UID_W-1:0]   i_user_id,
    input  logic [act_pkg::RIGHT_W-1:0] i_rights_bits,
    input  logic                        i_from_kernel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [act_pkg::RIGHT_W-1:0] o_rights_found,
    output logic                        o_granted,
    output logic [1:0]                  o_status
);

    act_pkg::t_state r_state, n_state;

    logic [act_pkg::RIGHT_W-1:0] r_default;
    logic [act_pkg::ENTRIES-1:0] r_valid;

    logic [1:0]                  r_kind;
    logic [act_pkg::UID_W-1:0]   r_uid;
    logic [act_pkg::RIGHT_W-1:0] r_req;
    logic                        r_kern;

    logic [act_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_cmp_vld;
    logic [act_pkg::IDX_W-1:0]   r_cmp_idx;

    logic                        r_hit;
    logic [act_pkg::IDX_W-1:0]   r_hit_idx;
    logic [act_pkg::RIGHT_W-1:0] r_hit_rights;
    logic                        r_free;
    logic [act_pkg::IDX_W-1:0]   r_free_idx;

    logic [act_pkg::RIGHT_W-1:0] r_rights_found;
    logic                        r_granted;
    logic [1:0]                  r_status;

    logic                        in_acc;
    logic                        out_acc;
    logic                        scan_last;
    logic                        cmp_hit;
    logic                        cmp_free;
    logic                        ram_we;
    logic [act_pkg::IDX_W-1:0]   ram_waddr;
    logic [act_pkg::IDX_W-1:0]   ram_raddr;
    act_pkg::t_entry             ram_wdata;
    act_pkg::t_entry             ram_rdata;
    logic [act_pkg::RIGHT_W-1:0] chk_rights;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = o_valid && i_ready;
    assign scan_last = (r_cnt == act_pkg::CNT_W'(act_pkg::ENTRIES));

    // comparator on the slot whose read data is now at the RAM output
    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (ram_rdata.user == r_uid);
    assign cmp_free = r_cmp_vld && !r_valid[r_cmp_idx];

    assign chk_rights = r_hit ? r_hit_rights : r_default;

    act_ram #(
        .WIDTH (act_pkg::ENTRY_W),
        .DEPTH (act_pkg::ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            act_pkg::S_IDLE:  if (in_acc)    n_state = act_pkg::S_SCAN;
            act_pkg::S_SCAN:  if (scan_last) n_state = act_pkg::S_WRITE;
            act_pkg::S_WRITE: n_state = act_pkg::S_OUT;
            act_pkg::S_OUT:   if (out_acc)   n_state = act_pkg::S_IDLE;
            default:          n_state = act_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_cnt[act_pkg::IDX_W-1:0];
        ram_waddr = r_hit ? r_hit_idx : r_free_idx;
        ram_wdata = '{user: r_uid, rights: r_req};
        case (r_state)
            act_pkg::S_IDLE:  o_ready = 1'b1;
            act_pkg::S_SCAN:  ;
            act_pkg::S_WRITE: ram_we = (r_kind == act_pkg::KIND_SET) && (r_hit || r_free);
            act_pkg::S_OUT:   o_valid = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= act_pkg::S_IDLE;
            r_default <= '0;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_default <= i_cfg_wr_data;
            end
            r_cmp_vld <= (r_state == act_pkg::S_SCAN) && !scan_last;
            if (r_state == act_pkg::S_WRITE) begin
                if (r_kind == act_pkg::KIND_SET && (r_hit || r_free)) begin
                    r_valid[ram_waddr] <= 1'b1;
                end else if (r_kind == act_pkg::KIND_DELETE && r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[act_pkg::IDX_W-1:0];
        if (in_acc) begin
            r_kind <= i_kind;
            r_uid  <= i_user_id;
            r_req  <= i_rights_bits;
            r_kern <= i_from_kernel;
            r_cnt  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_state == act_pkg::S_SCAN) begin
            if (!scan_last) begin
                r_cnt <= r_cnt + act_pkg::CNT_W'(1);
            end
            // keep the first match and the lowest free slot
            if (cmp_hit && !r_hit) begin
                r_hit        <= 1'b1;
                r_hit_idx    <= r_cmp_idx;
                r_hit_rights <= ram_rdata.rights;
            end
            if (cmp_free && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        if (r_state == act_pkg::S_WRITE) begin
            case (r_kind)
                act_pkg::KIND_CHECK: begin
                    r_rights_found <= chk_rights;
                    r_granted      <= r_kern || ((r_req & chk_rights) == r_req);
                    r_status       <= act_pkg::ST_OK;
                end
                act_pkg::KIND_SET: begin
                    r_rights_found <= '0;
                    r_granted      <= 1'b0;
                    r_status       <= (!r_hit && !r_free) ? act_pkg::ST_FULL : act_pkg::ST_OK;
                end
                act_pkg::KIND_DELETE: begin
                    r_rights_found <= '0;
                    r_granted      <= 1'b0;
                    r_status       <= r_hit ? act_pkg::ST_OK : act_pkg::ST_ABSENT;
                end
                default: begin
                    r_rights_found <= '0;
                    r_granted      <= 1'b0;
                    r_status       <= act_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_rights_found = r_rights_found;
    assign o_granted      = r_granted;
    assign o_status       = r_status;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("ready again right after accept");

    a_check_only_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind != act_pkg::KIND_CHECK) |-> (!o_granted && o_rights_found == '0))
        else $error("rights or grant reported for a non-check word");

    a_full_only_on_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == act_pkg::ST_FULL) |-> (r_kind == act_pkg::KIND_SET && r_valid == '1))
        else $error("table full reported while a slot is free or kind is not set");

endmodule

// ===== hw/rtl/act_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sim/access_control_table_top_test.sv =====
// ----------------------------------------------------------------------------
// Access control table testbench
// Drives check, set, delete and unused-kind words into the table. A
// scoreboard keeps its own copy of the slots and the default rights, works
// out the answer to each accepted word, and compares the returned words in
// order. The run covers a directed part, then random phases with different
// default rights and different idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module access_control_table_top_test;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         POOL_SIZE     = 20;
    localparam int         PHASE_WORDS   = 227;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [act_pkg::RIGHT_W-1:0] rights;
        logic                        granted;
        logic [1:0]                  status;
    } t_answer;

    class t_rights_table_model;
        bit                        slot_used[act_pkg::ENTRIES];
        bit [act_pkg::UID_W-1:0]   slot_uid[act_pkg::ENTRIES];
        bit [act_pkg::RIGHT_W-1:0] slot_rights[act_pkg::ENTRIES];
        bit [act_pkg::RIGHT_W-1:0] dflt_rights;
        t_answer                   expected_answers[$];
        int                        mismatches;
        int                        answers_seen;
        int                        grants;
        int                        denials;
        int                        full_sets;
        int                        absent_deletes;

        function int slot_of(bit [act_pkg::UID_W-1:0] uid);
            for (int i = 0; i < act_pkg::ENTRIES; i++) begin
                if (slot_used[i] && slot_uid[i] == uid) return i;
            end
            return -1;
        endfunction

        function bit [act_pkg::RIGHT_W-1:0] rights_of(bit [act_pkg::UID_W-1:0] uid);
            int s;
            s = slot_of(uid);
            return (s >= 0) ? slot_rights[s] : dflt_rights;
        endfunction

        // Work out the answer to one accepted word and update the slot copy.
        function void note_request(logic [1:0] kind, logic [act_pkg::UID_W-1:0] uid,
                                   logic [act_pkg::RIGHT_W-1:0] req, logic kern);
            t_answer a;
            int      s;
            a.rights  = '0;
            a.granted = 1'b0;
            a.status  = act_pkg::ST_OK;
            case (kind)
                act_pkg::KIND_CHECK: begin
                    a.rights  = rights_of(uid);
                    a.granted = kern || ((req & a.rights) == req);
                end
                act_pkg::KIND_SET: begin
                    s = slot_of(uid);
                    if (s < 0) begin
                        for (int i = act_pkg::ENTRIES - 1; i >= 0; i--) begin
                            if (!slot_used[i]) s = i;
                        end
                    end
                    if (s < 0) begin
                        a.status = act_pkg::ST_FULL;
                    end else begin
                        slot_used[s]   = 1'b1;
                        slot_uid[s]    = uid;
                        slot_rights[s] = req;
                    end
                end
                act_pkg::KIND_DELETE: begin
                    s = slot_of(uid);
                    if (s < 0) a.status = act_pkg::ST_ABSENT;
                    else slot_used[s] = 1'b0;
                end
                default: ;
            endcase
            expected_answers.push_back(a);
        endfunction

        function void check_answer(logic [act_pkg::RIGHT_W-1:0] rights, logic granted,
                                   logic [1:0] status);
            t_answer a;
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result word rights=%02h granted=%0b status=%0d",
                         $time, rights, granted, status);
                mismatches++;
                return;
            end
            a = expected_answers.pop_front();
            answers_seen++;
            if (rights !== a.rights) begin
                $display("%0t: rights_found expected %02h, got %02h", $time, a.rights, rights);
                mismatches++;
            end
            if (granted !== a.granted) begin
                $display("%0t: granted expected %0b, got %0b", $time, a.granted, granted);
                mismatches++;
            end
            if (status !== a.status) begin
                $display("%0t: status expected %0d, got %0d", $time, a.status, status);
                mismatches++;
            end
            if (a.status == act_pkg::ST_FULL) full_sets++;
            if (a.status == act_pkg::ST_ABSENT) absent_deletes++;
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [act_pkg::RIGHT_W-1:0] i_cfg_wr_data;
    logic                        i_valid;
    logic                        o_ready;
    logic [1:0]                  i_kind;
    logic [act_pkg::UID_W-1:0]   i_user_id;
    logic [act_pkg::RIGHT_W-1:0] i_rights_bits;
    logic                        i_from_kernel;
    logic                        o_valid;
    logic                        i_ready;
    logic [act_pkg::RIGHT_W-1:0] o_rights_found;
    logic                        o_granted;
    logic [1:0]                  o_status;

    t_rights_table_model         acl;
    int                          tx_idle_pct;
    int                          rx_stall_pct;
    bit                          rx_hold = 1'b0;
    int                          cycle_cnt = 0;
    logic [act_pkg::UID_W-1:0]   uid_pool[POOL_SIZE];

    access_control_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_user_id      (i_user_id),
        .i_rights_bits  (i_rights_bits),
        .i_from_kernel  (i_from_kernel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rights_found (o_rights_found),
        .o_granted      (o_granted),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words outstanding",
                     cycle_cnt, acl.expected_answers.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            acl.check_answer(o_rights_found, o_granted, o_status);
        end
    end

    // Offer one word, with random idle cycles ahead of it; return at the
    // falling edge after it is taken, valid still high.
    task automatic offer_word(input logic [1:0] kind, input logic [act_pkg::UID_W-1:0] uid,
                              input logic [act_pkg::RIGHT_W-1:0] bits, input logic kern);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_user_id     <= uid;
        i_rights_bits <= bits;
        i_from_kernel <= kern;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        acl.note_request(kind, uid, bits, kern);
        @(negedge i_clk);
    endtask

    task automatic drain_answers();
        i_valid <= 1'b0;
        while (acl.expected_answers.size() != 0) @(negedge i_clk);
        repeat (act_pkg::ENTRIES + 4) @(negedge i_clk);
    endtask

    task automatic write_default_rights(input logic [act_pkg::RIGHT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        acl.dflt_rights = value;
    endtask

    task automatic hold_receiver(input int cycles);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 1'b0;
    endtask

    // Small uid pool so the table fills up; every third entry differs from the one before it in one bit.
    task automatic refill_uid_pool();
        uid_pool[0] = '0;
        uid_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            if (i % 3 == 0) uid_pool[i] = uid_pool[i-1] ^ (32'd1 << $urandom_range(31));
            else uid_pool[i] = $urandom;
        end
    endtask

    task automatic run_random_words(input int count);
        int                          sent;
        int                          pick;
        logic [1:0]                  kind;
        logic [act_pkg::UID_W-1:0]   uid;
        logic [act_pkg::RIGHT_W-1:0] bits;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 40) kind = act_pkg::KIND_CHECK;
            else if (pick < 75) kind = act_pkg::KIND_SET;
            else if (pick < 95) kind = act_pkg::KIND_DELETE;
            else kind = KIND_UNUSED;
            uid = ($urandom_range(99) < 85) ? uid_pool[$urandom_range(POOL_SIZE - 1)]
                                            : $urandom;
            case ($urandom_range(3))
                0: bits = act_pkg::RIGHT_W'($urandom);
                1: bits = act_pkg::RIGHT_W'($urandom & $urandom & $urandom);
                2: bits = $urandom_range(1) ? '1 : '0;
                default: bits = acl.rights_of(uid) & act_pkg::RIGHT_W'($urandom);
            endcase
            offer_word(kind, uid, bits, $urandom_range(3) == 0);
            sent++;
        end
    endtask

    initial begin
        acl           = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_kind        = act_pkg::KIND_CHECK;
        i_user_id     = '0;
        i_rights_bits = '0;
        i_from_kernel = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table answers with the reset default; kernel always wins.
        offer_word(act_pkg::KIND_CHECK,  32'h0000_0000, 8'h00, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hFFFF_FFFF, 8'hFF, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hFFFF_FFFF, 8'hFF, 1'b1);
        offer_word(act_pkg::KIND_DELETE, 32'h0000_0000, 8'h00, 1'b0);
        offer_word(act_pkg::KIND_SET,    32'h0000_0000, 8'hFF, 1'b0);
        offer_word(act_pkg::KIND_SET,    32'hFFFF_FFFF, 8'h00, 1'b1);
        offer_word(act_pkg::KIND_CHECK,  32'h0000_0000, 8'hFF, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hFFFF_FFFF, 8'h01, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hFFFF_FFFF, 8'h01, 1'b1);
        // Update in place, then a request one bit beyond what is held.
        offer_word(act_pkg::KIND_SET,    32'h0000_0000, 8'h5A, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'h0000_0000, 8'h5B, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'h0000_0000, 8'h5A, 1'b0);
        offer_word(KIND_UNUSED,          32'h0000_0000, 8'hFF, 1'b1);
        offer_word(act_pkg::KIND_DELETE, 32'hFFFF_FFFF, 8'h00, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hFFFF_FFFF, 8'h00, 1'b0);
        offer_word(act_pkg::KIND_DELETE, 32'hFFFF_FFFF, 8'h00, 1'b0);
        offer_word(act_pkg::KIND_SET,    32'hA5A5_5A5A, 8'h81, 1'b0);
        offer_word(act_pkg::KIND_CHECK,  32'hA5A5_5A5B, 8'h80, 1'b0);
        drain_answers();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_default_rights(8'hFF); tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin write_default_rights(8'h00); tx_idle_pct = 67; rx_stall_pct = 0;  end
                2: begin
                    write_default_rights(act_pkg::RIGHT_W'($urandom));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 67;
                end
                3: begin write_default_rights(8'h5A); tx_idle_pct = 7;  rx_stall_pct = 7;  end
                default: begin
                    write_default_rights(8'h80);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 20;
                    fork
                        hold_receiver(HOLD_CYCLES);
                    join_none
                end
            endcase
            refill_uid_pool();
            if (phase == 0) offer_word(act_pkg::KIND_CHECK, 32'h1234_5678, 8'hFF, 1'b0);
            run_random_words(PHASE_WORDS);
            drain_answers();
        end

        $display("Checked %0d result words over five default-rights settings and five",
                 acl.answers_seen);
        $display("idle patterns, including %0d sets into a full table and %0d absent deletes",
                 acl.full_sets, acl.absent_deletes);
        if (acl.mismatches == 0 && acl.expected_answers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/act_pkg.sv
hw/rtl/act_ram.sv
hw/rtl/access_control_table_top.sv
sim/access_control_table_top_test.sv
